// File: sv/lnc_pkg.sv
// Shared types, constants and the name folding function for the LRU name cache.
package lnc_pkg;

  // Widest index and count over the supported range of entry counts (1 to 256)
  localparam int unsigned ENTRY_W_MAX = 8;
  localparam int unsigned CNT_W_MAX   = 9;
  localparam int unsigned RAW_BYTES   = 20;
  localparam int unsigned RAW_W       = 8 * RAW_BYTES;

  localparam logic [2:0]  HIT_COST  = 3'd1;
  localparam logic [2:0]  MISS_COST = 3'd5;
  localparam logic [31:0] COST_MAX  = 32'hFFFF_FFFF;

  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] CASE_DIFF = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  // Recency update request to the rank file
  typedef struct packed {
    logic                   update;
    logic [ENTRY_W_MAX-1:0] entry;
    logic [ENTRY_W_MAX-1:0] old_rank;
    logic [CNT_W_MAX-1:0]   count;
  } rank_ctl_t;

  // Outcome of one lookup walk
  typedef struct packed {
    logic                   done;
    logic                   hit;
    logic [ENTRY_W_MAX-1:0] hit_idx;
    logic [ENTRY_W_MAX-1:0] hit_rank;
    logic [ENTRY_W_MAX-1:0] victim;
  } scan_stat_t;

  // Fold a..z to upper case and zero every byte at or beyond nbytes
  function automatic logic [RAW_W-1:0] fold_name(input logic [RAW_W-1:0] raw,
                                                 input int unsigned nbytes);
    logic [RAW_W-1:0] res;
    logic [7:0]       byte_v;
    res = '0;
    for (int unsigned b = 0; b < RAW_BYTES; b++) begin
      byte_v = raw[8*b +: 8];
      if (b >= nbytes) begin
        byte_v = 8'h00;
      end else if (byte_v >= LOWER_A && byte_v <= LOWER_Z) begin
        byte_v = byte_v - CASE_DIFF;
      end
      res[8*b +: 8] = byte_v;
    end
    return res;
  endfunction

endpackage

// File: sv/lru_name_cache_cost_top.sv
// Top level of the LRU name cache with running access cost.
// Fully associative cache of up to MAX_ENTRIES names of NAME_BYTES bytes,
// folded to upper case, with true least-recently-used replacement. Each
// request returns hit, its cost (1 on a hit, 5 on a miss) and the saturating
// running cost. One request is worked on at a time, set by the single
// comparator that walks the stored names one per cycle through the read port
// of the name RAM. On a miss the walk covers every filled entry, while a hit
// ends the walk early at the matching entry. The next request is taken the
// cycle after the result is loaded.
// A finished result waits in an output register, so a new request is taken
// while it is still stalled.
// Writing capacity flushes the cache and keeps the running cost; a capacity
// above MAX_ENTRIES acts as MAX_ENTRIES and zero makes every request a miss.
module lru_name_cache_cost_top #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned NAME_BYTES  = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] name_part0,
  input  logic [63:0] name_part1,
  input  logic [31:0] name_part2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [2:0]  access_cost,
  output logic [31:0] running_cost
);

  localparam int unsigned IDX_W = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KEY_W = 8 * NAME_BYTES;
  localparam int unsigned EW    = lnc_pkg::ENTRY_W_MAX;
  localparam int unsigned CW    = lnc_pkg::CNT_W_MAX;

  lnc_pkg::state_t     state;
  lnc_pkg::state_t     state_next;
  lnc_pkg::rank_ctl_t  rank_ctl;
  lnc_pkg::scan_stat_t scan_stat;

  logic [5:0]       capacity;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] filled;
  logic [CNT_W-1:0] filled_next;
  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] ram_rdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_we;
  logic [IDX_W-1:0] pend_idx;
  logic [IDX_W-1:0] pend_rank;
  logic [31:0]      total_cost;
  logic [31:0]      total_next;
  logic [2:0]       cost;
  logic             accept;
  logic             load_out;
  logic [lnc_pkg::RAW_W-1:0] folded;

  assign accept = in_valid && !in_stall;
  assign folded = lnc_pkg::fold_name({name_part2, name_part1, name_part0}, NAME_BYTES);

  always_comb begin
    if (32'(capacity) > MAX_ENTRIES) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  assign cost = scan_stat.hit ? lnc_pkg::HIT_COST : lnc_pkg::MISS_COST;

  always_comb begin
    if (total_cost > lnc_pkg::COST_MAX - 32'(cost)) begin
      total_next = lnc_pkg::COST_MAX;
    end else begin
      total_next = total_cost + 32'(cost);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lnc_pkg::ST_IDLE:   if (accept) state_next = lnc_pkg::ST_SCAN;
      lnc_pkg::ST_SCAN:   if (scan_stat.done) state_next = lnc_pkg::ST_UPDATE;
      lnc_pkg::ST_UPDATE: state_next = lnc_pkg::ST_DONE;
      lnc_pkg::ST_DONE:   if (load_out) state_next = lnc_pkg::ST_IDLE;
      default:            state_next = lnc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall    = 1'b1;
    load_out    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    rank_ctl    = '0;
    filled_next = filled;
    case (state)
      lnc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      lnc_pkg::ST_UPDATE: begin
        if (cap_eff != '0) begin
          rank_ctl.update = 1'b1;
          if (scan_stat.hit) begin
            rank_ctl.entry    = scan_stat.hit_idx;
            rank_ctl.old_rank = scan_stat.hit_rank;
            rank_ctl.count    = CW'(filled);
          end else if (filled < cap_eff) begin
            // fill the next free entry
            ram_we            = 1'b1;
            ram_waddr         = filled[IDX_W-1:0];
            filled_next       = filled + 1'b1;
            rank_ctl.entry    = EW'(filled[IDX_W-1:0]);
            rank_ctl.old_rank = EW'(filled[IDX_W-1:0]);
            rank_ctl.count    = CW'(filled_next);
          end else begin
            // replace the least recent entry
            ram_we            = 1'b1;
            ram_waddr         = scan_stat.victim[IDX_W-1:0];
            rank_ctl.entry    = scan_stat.victim;
            rank_ctl.old_rank = EW'(IDX_W'(filled - 1'b1));
            rank_ctl.count    = CW'(filled);
          end
        end
      end
      lnc_pkg::ST_DONE: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lnc_pkg::ST_IDLE;
      capacity   <= '0;
      filled     <= '0;
      total_cost <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
        filled   <= '0;
      end else begin
        filled <= filled_next;
      end
      if (load_out) begin
        total_cost <= total_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_q <= folded[KEY_W-1:0];
    end
    if (load_out) begin
      hit          <= scan_stat.hit;
      access_cost  <= cost;
      running_cost <= total_next;
    end
  end

  lnc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_names (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_q),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lnc_scan #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .KEY_W       (KEY_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .count     (filled),
    .key       (key_q),
    .rd_data   (ram_rdata),
    .pend_rank (pend_rank),
    .rd_addr   (ram_raddr),
    .pend_idx  (pend_idx),
    .stat      (scan_stat)
  );

  lnc_rank #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_rank (
    .clk     (clk),
    .rst     (rst),
    .ctl     (rank_ctl),
    .rd_idx  (pend_idx),
    .rd_rank (pend_rank)
  );

endmodule

// File: sv/lnc_ram.sv
// Generic simple dual-port RAM with registered read.
module lnc_ram #(
  parameter int unsigned WIDTH = 160,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/lnc_rank.sv
// Recency rank file: one rank per entry, aged in parallel on each promotion.
module lnc_rank #(
  parameter int unsigned MAX_ENTRIES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lnc_pkg::rank_ctl_t   ctl,
  input  logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_idx,
  output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_rank
);

  localparam int unsigned IDX_W = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [IDX_W-1:0] rank_q [MAX_ENTRIES];
  logic [IDX_W-1:0] upd_entry;
  logic [IDX_W-1:0] upd_old;
  logic [CNT_W-1:0] upd_count;

  assign upd_entry = ctl.entry[IDX_W-1:0];
  assign upd_old   = ctl.old_rank[IDX_W-1:0];
  assign upd_count = ctl.count[CNT_W-1:0];
  assign rd_rank   = rank_q[rd_idx];

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_rank
    always_ff @(posedge clk) begin
      if (rst) begin
        rank_q[i] <= '0;
      end else if (ctl.update) begin
        if (upd_entry == IDX_W'(i)) begin
          rank_q[i] <= '0;
        end else if (CNT_W'(i) < upd_count && rank_q[i] < upd_old) begin
          // age entries that were more recent than the promoted one
          rank_q[i] <= rank_q[i] + 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/lnc_scan.sv
// Lookup walker: one shared comparator steps through the filled entries.
module lnc_scan #(
  parameter int unsigned MAX_ENTRIES = 32,
  parameter int unsigned KEY_W       = 160
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [$clog2(MAX_ENTRIES + 1)-1:0] count,
  input  logic [KEY_W-1:0]        key,
  input  logic [KEY_W-1:0]        rd_data,
  input  logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] pend_rank,
  output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] rd_addr,
  output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] pend_idx,
  output lnc_pkg::scan_stat_t     stat
);

  localparam int unsigned IDX_W = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned EW    = lnc_pkg::ENTRY_W_MAX;

  logic             busy;
  logic             pend;
  logic [CNT_W-1:0] scan_idx;
  logic             done;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic [IDX_W-1:0] victim;
  logic             match;
  logic [IDX_W-1:0] last_rank;

  assign rd_addr   = scan_idx[IDX_W-1:0];
  assign match     = pend && (rd_data == key);
  assign last_rank = IDX_W'(count - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        pend     <= 1'b0;
        hit      <= 1'b0;
        scan_idx <= '0;
        victim   <= '0;
      end else if (busy) begin
        // least recent entry is the replacement candidate
        if (pend && pend_rank == last_rank) begin
          victim <= pend_idx;
        end
        if (match) begin
          hit      <= 1'b1;
          hit_idx  <= pend_idx;
          hit_rank <= pend_rank;
          pend     <= 1'b0;
          busy     <= 1'b0;
          done     <= 1'b1;
        end else if (scan_idx < count) begin
          pend     <= 1'b1;
          pend_idx <= scan_idx[IDX_W-1:0];
          scan_idx <= scan_idx + 1'b1;
        end else begin
          pend <= 1'b0;
          if (!pend) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    stat          = '0;
    stat.done     = done;
    stat.hit      = hit;
    stat.hit_idx  = EW'(hit_idx);
    stat.hit_rank = EW'(hit_rank);
    stat.victim   = EW'(victim);
  end

endmodule

// File: sv/lnc_checker.sv
// Port-level checks for the LRU name cache, bound to the top level.
module lnc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        hit,
  input logic [2:0]  access_cost,
  input logic [31:0] running_cost
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({hit, access_cost, running_cost}))
    else $error("stalled result changed");

  // cost follows the hit flag
  a_cost: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hit && access_cost == 3'd1) || (!hit && access_cost == 3'd5))
    else $error("access cost does not match hit");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  // running cost never falls
  a_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid || running_cost >= $past(running_cost))
    else $error("running cost decreased");

endmodule

bind lru_name_cache_cost_top lnc_checker u_lnc_checker (.*);

// File: verif/lru_name_cache_cost_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the LRU name cache: random and directed lookups against a predictor.
module lru_name_cache_cost_top_tb;

  localparam int unsigned MAX_ENTRIES   = 32;
  localparam int unsigned NAME_BYTES    = 20;
  localparam int unsigned CLK_HALF_NS   = 6;
  localparam int unsigned RST_CYCLES    = 6;
  localparam int unsigned BLOCK_LATENCY = 40;
  localparam int unsigned GAP_MAX       = 19;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned PHASE_ITEMS   = 140;
  localparam int unsigned REPORT_MAX    = 200;

  typedef logic [8*NAME_BYTES-1:0] name_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  cost;
    logic [31:0] total;
  } lookup_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        cfg_we       = 1'b0;
  logic [5:0]  cfg_wdata    = '0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [63:0] name_part0   = '0;
  logic [63:0] name_part1   = '0;
  logic [31:0] name_part2   = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        hit;
  logic [2:0]  access_cost;
  logic [31:0] running_cost;

  // Predicted cache contents
  name_t       cached_name [MAX_ENTRIES];
  int unsigned age_rank    [MAX_ENTRIES];
  int unsigned n_filled    = 0;
  logic [31:0] cost_total  = '0;
  logic [5:0]  cap_reg     = '0;

  // Ring of predicted results still to come
  lookup_t     awaited [16];
  logic [3:0]  exp_wr      = '0;
  logic [3:0]  exp_rd      = '0;

  name_t       name_pool [64];
  int unsigned pool_n      = 1;
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;
  int unsigned hold_cycles = 0;

  lru_name_cache_cost_top #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .name_part0  (name_part0),
    .name_part1  (name_part1),
    .name_part2  (name_part2),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .access_cost (access_cost),
    .running_cost(running_cost)
  );

  always #(CLK_HALF_NS) clk = ~clk;

  function automatic name_t upper_key(input name_t raw);
    name_t      k;
    logic [7:0] c;
    for (int unsigned b = 0; b < NAME_BYTES; b++) begin
      c = raw[8*b +: 8];
      // fold a..z only
      if (c >= 8'h61 && c <= 8'h7A) begin
        c = c - 8'h20;
      end
      k[8*b +: 8] = c;
    end
    return k;
  endfunction

  function automatic void make_recent(input int unsigned e);
    int unsigned prev;
    prev = age_rank[e];
    for (int unsigned i = 0; i < n_filled; i++) begin
      if (age_rank[i] < prev) begin
        age_rank[i]++;
      end
    end
    age_rank[e] = 0;
  endfunction

  function automatic void predict_lookup(input name_t raw);
    name_t       key;
    int unsigned cap_eff;
    int unsigned e;
    bit          found;
    logic [2:0]  cost;
    lookup_t     r;
    key     = upper_key(raw);
    cap_eff = (cap_reg > MAX_ENTRIES) ? MAX_ENTRIES : cap_reg;
    found   = 1'b0;
    e       = 0;
    if (cap_eff != 0) begin
      for (int unsigned i = 0; i < n_filled; i++) begin
        if (!found && cached_name[i] == key) begin
          found = 1'b1;
          e     = i;
        end
      end
      if (!found) begin
        if (n_filled < cap_eff) begin
          e = n_filled;
          n_filled++;
          age_rank[e] = n_filled - 1;
        end else begin
          // replace the least recent entry
          for (int unsigned i = 0; i < n_filled; i++) begin
            if (age_rank[i] == n_filled - 1) begin
              e = i;
            end
          end
        end
        cached_name[e] = key;
      end
      make_recent(e);
    end
    cost = found ? lnc_pkg::HIT_COST : lnc_pkg::MISS_COST;
    if (cost_total > lnc_pkg::COST_MAX - 32'(cost)) begin
      cost_total = lnc_pkg::COST_MAX;
    end else begin
      cost_total = cost_total + 32'(cost);
    end
    r.hit   = found;
    r.cost  = cost;
    r.total = cost_total;
    awaited[exp_wr] = r;
    exp_wr = exp_wr + 1'b1;
  endfunction

  task automatic send_name(input name_t raw);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    name_part0 <= raw[63:0];
    name_part1 <= raw[127:64];
    name_part2 <= raw[159:128];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_lookup(raw);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_wr != exp_rd) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [5:0] value);
    wait_drained();
    repeat (BLOCK_LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cap_reg  = value;
    n_filled = 0;
  endtask

  function automatic name_t str_name(input string s);
    name_t n;
    n = '0;
    for (int i = 0; i < s.len() && i < NAME_BYTES; i++) begin
      n[8*i +: 8] = s[i];
    end
    return n;
  endfunction

  function automatic name_t word_name();
    name_t       n;
    int unsigned len;
    n   = '0;
    len = $urandom_range(1, NAME_BYTES);
    for (int unsigned b = 0; b < len; b++) begin
      if ($urandom_range(0, 4) == 0) begin
        n[8*b +: 8] = 8'h30 + 8'($urandom_range(0, 9));
      end else begin
        n[8*b +: 8] = 8'h41 + 8'($urandom_range(0, 25));
      end
    end
    return n;
  endfunction

  function automatic name_t vary_case(input name_t n);
    name_t      v;
    logic [7:0] c;
    v = n;
    for (int unsigned b = 0; b < NAME_BYTES; b++) begin
      c = n[8*b +: 8];
      if (c >= 8'h41 && c <= 8'h5A && $urandom_range(0, 1) == 1) begin
        v[8*b +: 8] = c + 8'h20;
      end
    end
    return v;
  endfunction

  // Bytes around the folding range and the top of the byte
  function automatic name_t boundary_name();
    name_t       n;
    int unsigned len;
    logic [7:0]  c;
    n   = '0;
    len = $urandom_range(1, NAME_BYTES);
    for (int unsigned b = 0; b < len; b++) begin
      case ($urandom_range(0, 11))
        0:       c = 8'h00;
        1:       c = 8'h40;
        2:       c = 8'h41;
        3:       c = 8'h5A;
        4:       c = 8'h5B;
        5:       c = 8'h60;
        6:       c = 8'h61;
        7:       c = 8'h7A;
        8:       c = 8'h7B;
        9:       c = 8'h7F;
        10:      c = 8'h80;
        default: c = 8'hFF;
      endcase
      n[8*b +: 8] = c;
    end
    return n;
  endfunction

  function automatic name_t noise_name();
    return {$urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // Result sink: stall per result, or hold off for a long stretch on request
  initial begin : result_sink
    int unsigned pause;
    forever begin
      if (hold_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        pause = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (pause != 0) begin
          out_stall <= 1'b1;
          repeat (pause) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid && hold_cycles == 0) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_result
    lookup_t want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_wr == exp_rd) begin
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
          $display("%0t: unexpected result, expected none, actual hit %0d cost %0d total %0d",
                   $time, hit, access_cost, running_cost);
        end
      end else begin
        want   = awaited[exp_rd];
        exp_rd = exp_rd + 1'b1;
        if (hit !== want.hit) begin
          flag_mismatch("hit", 32'(want.hit), 32'(hit));
        end
        if (access_cost !== want.cost) begin
          flag_mismatch("access_cost", 32'(want.cost), 32'(access_cost));
        end
        if (running_cost !== want.total) begin
          flag_mismatch("running_cost", want.total, running_cost);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Capacity is zero out of reset: nothing is ever cached
  task automatic test_capacity_zero();
    send_name(str_name("KEEP"));
    send_name(str_name("KEEP"));
  endtask

  task automatic test_case_folding();
    name_t gap_name;
    set_capacity(6'd4);
    send_name('0);
    send_name('1);
    send_name('0);
    send_name(str_name("azAZ09"));
    send_name(str_name("AZaz09"));
    send_name(str_name("abcdefghijklmnopqrst"));
    send_name(str_name("ABCDEFGHIJKLMNOPQRST"));
    // characters next to the letter ranges stay as they are
    send_name(str_name("`{"));
    send_name(str_name("@["));
    // a zero byte inside a name makes a distinct key
    gap_name = str_name("ABXCD");
    gap_name[23:16] = 8'h00;
    send_name(gap_name);
    send_name(str_name("ABCD"));
  endtask

  task automatic test_lru_order();
    set_capacity(6'd2);
    send_name(str_name("ALPHA"));
    send_name(str_name("BRAVO"));
    send_name(str_name("alpha"));
    send_name(str_name("CHARLIE"));
    send_name(str_name("BRAVO"));
    send_name(str_name("ALPHA"));
  endtask

  task automatic test_flush_on_write();
    set_capacity(6'd3);
    send_name(str_name("DELTA"));
    send_name(str_name("DELTA"));
    set_capacity(6'd3);
    send_name(str_name("DELTA"));
    set_capacity(6'd1);
    send_name(str_name("ECHO"));
    send_name(str_name("FOXTROT"));
    send_name(str_name("echo"));
  endtask

  task automatic test_back_pressure();
    name_t burst_names [3];
    burst_names[0] = str_name("GOLF");
    burst_names[1] = str_name("HOTEL");
    burst_names[2] = str_name("INDIA");
    set_capacity(6'd8);
    tx_burst    = 1'b1;
    hold_cycles = HOLD_CYCLES;
    for (int unsigned i = 0; i < 12; i++) begin
      send_name(burst_names[i % 3]);
    end
    // pause until every result has come back
    wait_drained();
    tx_burst = 1'b0;
    for (int unsigned i = 0; i < 4; i++) begin
      send_name(str_name("golf"));
    end
  endtask

  task automatic run_phase(input logic [5:0] cap, input bit tx_fast, input bit rx_fast);
    int unsigned cap_eff;
    int unsigned pick;
    set_capacity(cap);
    tx_burst = tx_fast;
    rx_burst = rx_fast;
    cap_eff  = (cap > MAX_ENTRIES) ? MAX_ENTRIES : cap;
    pool_n   = (cap_eff == 0) ? 6 : cap_eff + $urandom_range(0, cap_eff / 2 + 2);
    if (pool_n > 64) begin
      pool_n = 64;
    end
    for (int unsigned i = 0; i < pool_n; i++) begin
      name_pool[i] = ($urandom_range(0, 7) == 0) ? boundary_name() : word_name();
    end
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_name(vary_case(name_pool[$urandom_range(0, pool_n - 1)]));
      end else if (pick < 90) begin
        send_name(boundary_name());
      end else begin
        send_name(noise_name());
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  task automatic test_random_sweep();
    logic [5:0] caps [11];
    caps = '{6'd1, 6'd2, 6'd5, 6'd16, 6'd31, 6'd32, 6'd33, 6'd63, 6'd0,
             6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))};
    for (int unsigned k = 0; k < 11; k++) begin
      run_phase(caps[k], k % 4 == 1 || k % 4 == 3, k % 4 == 2 || k % 4 == 3);
    end
  endtask

  initial begin
    rst <= 1'b1;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_capacity_zero();
    test_case_folding();
    test_lru_order();
    test_flush_on_write();
    test_back_pressure();
    test_random_sweep();
    wait_drained();
    repeat (BLOCK_LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
